FILE: design/gbtf_pkg.sv
`default_nettype none

package gbtf_pkg;

   localparam int ValueWidth = 31;
   localparam int CountWidth = $clog2(ValueWidth);

   typedef logic [ValueWidth-1:0] value_type;
   typedef logic [CountWidth-1:0] count_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic set_one;
      logic step;
      logic scale;
      logic emit;
   } gbtf_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic trivial;
      logic equal;
      logic count_zero;
   } gbtf_status_type;

endpackage

`default_nettype wire

FILE: design/gbtf_datapath.sv
`default_nettype none

module gbtf_datapath
   import gbtf_pkg::*;
(
   input  wire logic            clock,
   input  wire gbtf_cmd_type    cmd,
   input  wire value_type       req_first_value,
   input  wire value_type       req_second_value,
   output gbtf_status_type      status,
   output value_type            rsp_divisor_result
);

   value_type a_ff, a_in;
   value_type b_ff, b_in;
   count_type k_ff, k_in;
   value_type res_ff, res_in;

   logic      a_gt_b;
   value_type diff;

   assign a_gt_b = a_ff > b_ff;
   assign diff   = a_gt_b ? (a_ff - b_ff) : (b_ff - a_ff);

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      k_in   = k_ff;
      res_in = res_ff;
      if (cmd.load) begin
         a_in = req_first_value;
         b_in = req_second_value;
         k_in = '0;
      end else if (cmd.step) begin
         if (!a_ff[0] && !b_ff[0]) begin
            // common factor of two: remember it for the final scale
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = CountWidth'(k_ff + 1'b1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_gt_b) begin
            // both odd: the difference is even, drop its factor of two at once
            a_in = diff >> 1;
         end else begin
            b_in = diff >> 1;
         end
      end else if (cmd.scale) begin
         a_in = a_ff << 1;
         k_in = CountWidth'(k_ff - 1'b1);
      end
      if (cmd.set_one) begin
         res_in = ValueWidth'(1);
      end else if (cmd.emit) begin
         res_in = a_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      k_ff   <= k_in;
      res_ff <= res_in;
   end

   assign status.trivial    = (a_ff[ValueWidth-1:1] == '0) || (b_ff[ValueWidth-1:1] == '0);
   assign status.equal      = (a_ff == b_ff);
   assign status.count_zero = (k_ff == '0);

   assign rsp_divisor_result = res_ff;

endmodule

`default_nettype wire

FILE: design/gbtf_controller.sv
`default_nettype none

module gbtf_controller
   import gbtf_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire gbtf_status_type status,
   output logic                 busy,
   output gbtf_cmd_type         cmd,
   output logic                 rsp_valid
);

   typedef enum logic [1:0] {
      IDLE,
      CHECK,
      REDUCE,
      SCALE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = CHECK;
            end
         end
         CHECK: begin
            if (status.trivial) begin
               // an operand of zero or one gives one
               cmd.set_one  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end else begin
               state_in = REDUCE;
            end
         end
         REDUCE: begin
            if (status.equal) begin
               state_in = SCALE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         SCALE: begin
            if (status.count_zero) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end else begin
               cmd.scale = 1'b1;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

FILE: design/gcd_by_trial_factorization.sv
`default_nettype none

// Greatest common divisor of two unsigned operands. A word is taken when
// start is high and busy is low; the result appears on rsp_divisor_result for
// exactly one cycle with rsp_valid and cannot be held off, so the receiver
// must take it then. An operand of zero or one gives a result of one. The
// work runs a binary subtract-and-shift loop, one step per cycle: each step
// halves one or both operands or replaces the larger of two odd operands by
// half their difference, and common factors of two are restored one shift per
// cycle at the end. busy drops in the cycle the result is shown, so the next
// word may be started right away.
module gcd_by_trial_factorization
   import gbtf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   output logic           busy,
   input  wire value_type req_first_value,
   input  wire value_type req_second_value,
   output logic           rsp_valid,
   output value_type      rsp_divisor_result
);

   gbtf_cmd_type    cmd;
   gbtf_status_type status;

   gbtf_datapath u_datapath (
      .clock              (clock),
      .cmd                (cmd),
      .req_first_value    (req_first_value),
      .req_second_value   (req_second_value),
      .status             (status),
      .rsp_divisor_result (rsp_divisor_result)
   );

   gbtf_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .busy      (busy),
      .cmd       (cmd),
      .rsp_valid (rsp_valid)
   );

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy)
      else $error("operands loaded while busy");

   a_result_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_result_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_divisor_result != '0) && !busy)
      else $error("zero result or result shown while busy");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_gcd_by_trial_factorization.sv
`default_nettype none

module tb_gcd_by_trial_factorization;
   timeunit 1ns;
   timeprecision 1ps;

   import gbtf_pkg::*;

   localparam int ClockPeriod = 20;
   localparam int ResetCycles = 7;
   localparam int GapMax = 18;
   localparam int SettleCycles = 120;
   localparam value_type MaxValue = {ValueWidth{1'b1}};

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   value_type req_first_value = '0;
   value_type req_second_value = '0;
   logic      rsp_valid;
   value_type rsp_divisor_result;

   value_type gcd_pending[$];
   int        words_sent = 0;
   int        words_checked = 0;
   int        errors = 0;
   bit        idling_on = 1'b1;

   gcd_by_trial_factorization u_top (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_first_value    (req_first_value),
      .req_second_value   (req_second_value),
      .rsp_valid          (rsp_valid),
      .rsp_divisor_result (rsp_divisor_result)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // Zero or one on either side short-circuits to one, as the trial loop never runs.
   function automatic value_type gcd_of(value_type a, value_type b);
      value_type remainder;
      if (a <= 1 || b <= 1) return value_type'(1);
      remainder = a % b;
      while (remainder != 0) begin
         a = b;
         b = remainder;
         remainder = a % b;
      end
      return b;
   endfunction

   function automatic value_type random_operand();
      int w;
      w = $urandom_range(1, ValueWidth);
      return value_type'($urandom) >> (ValueWidth - w);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (gcd_pending.size() == 0) begin
            errors++;
            $display("%0t: result with none expected: expected none, actual %0d",
                     $time, rsp_divisor_result);
         end else begin
            if (rsp_divisor_result !== gcd_pending[0]) begin
               errors++;
               $display("%0t: divisor_result mismatch: expected %0d, actual %0d",
                        $time, gcd_pending[0], rsp_divisor_result);
            end
            void'(gcd_pending.pop_front());
            words_checked++;
         end
      end
   end

   // Call at a rising edge; returns at the edge that takes the word.
   task automatic send_word(input value_type a, input value_type b);
      start <= 1'b1;
      req_first_value <= a;
      req_second_value <= b;
      do @(posedge clock); while (busy !== 1'b0);
      gcd_pending.push_back(gcd_of(a, b));
      words_sent++;
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      req_first_value <= value_type'($urandom);
      req_second_value <= value_type'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_idle();
      if (idling_on && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, GapMax));
   endtask

   task automatic wait_drain();
      if (start !== 1'b0) start <= 1'b0;
      while (gcd_pending.size() != 0) @(posedge clock);
   endtask

   task automatic send_and_gap(input value_type a, input value_type b);
      send_word(a, b);
      maybe_idle();
   endtask

   task automatic test_corner_cases();
      send_and_gap(1, 1);
      send_and_gap(1, MaxValue);
      send_and_gap(MaxValue, 1);
      send_and_gap(MaxValue, MaxValue);
      send_and_gap(0, 7);
      send_and_gap(12, 0);
      send_and_gap(0, 0);
      send_and_gap(0, MaxValue);
      send_and_gap(MaxValue, 0);
      send_and_gap(MaxValue - 1, 2);
      send_and_gap(MaxValue, MaxValue - 1);
      send_and_gap(value_type'(1) << 30, value_type'(1) << 30);
      send_and_gap(value_type'(1) << 30, value_type'(3) << 28);
      send_and_gap(1836311903, 1134903170);
      send_and_gap(48, 18);
      send_and_gap(6, 35);
      send_and_gap(1000000, value_type'(1) << 20);
      send_and_gap(111546435, 2 * 111546435 / 5);
      send_and_gap(96, 96);
      send_and_gap(2, 3);
   endtask

   task automatic test_random(input int count, input bit vary_idling);
      value_type a, b, swap;
      int        sel, gw, xw;
      longint unsigned g, x, y;
      for (int i = 0; i < count; i++) begin
         if (vary_idling && i % 15 == 0) idling_on = ($urandom_range(0, 2) != 0);
         sel = $urandom_range(0, 9);
         case (sel)
            0: begin
               a = value_type'($urandom_range(0, 1));
               b = random_operand();
            end
            1, 2, 3, 4, 5: begin
               // build both operands around a common factor
               gw = $urandom_range(1, ValueWidth - 1);
               xw = ValueWidth - gw;
               g = $urandom_range(1, (1 << gw) - 1);
               x = $urandom_range(1, (1 << xw) - 1);
               y = $urandom_range(1, (1 << xw) - 1);
               a = value_type'(g * x);
               b = value_type'(g * y);
            end
            6, 7: begin
               a = value_type'($urandom);
               b = value_type'($urandom);
            end
            8: begin
               a = random_operand();
               b = random_operand();
            end
            default: begin
               a = value_type'(random_operand() << $urandom_range(0, 20));
               b = value_type'(random_operand() << $urandom_range(0, 20));
            end
         endcase
         if ($urandom_range(0, 1) == 1) begin
            swap = a;
            a = b;
            b = swap;
         end
         send_and_gap(a, b);
      end
   endtask

   // Let each word run alone through an empty pipe.
   task automatic test_drain_pause();
      for (int i = 0; i < 5; i++) begin
         wait_drain();
         hold_off($urandom_range(1, GapMax));
         send_word(random_operand(), random_operand());
      end
      wait_drain();
   endtask

   task automatic test_back_to_back(input int count);
      idling_on = 1'b0;
      test_random(count, 1'b0);
   endtask

   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_cases();
      test_random(30, 1'b1);
      test_drain_pause();
      test_random(30, 1'b1);
      test_back_to_back(15);

      wait_drain();
      repeat (SettleCycles) @(posedge clock);
      if (gcd_pending.size() != 0) begin
         errors += gcd_pending.size();
         $display("%0t: results missing: expected %0d more, actual 0",
                  $time, gcd_pending.size());
      end
      $display("%0d words sent, %0d results checked, %0d failures",
               words_sent, words_checked, errors);
      $display("covered zero and one operands, width extremes, shared factors, powers of two,");
      $display("random idle bursts, a fully drained pause and back-to-back words");
      if (errors == 0) begin
         $display("tb_gcd_by_trial_factorization: PASS");
      end else begin
         $display("tb_gcd_by_trial_factorization: FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_gcd_by_trial_factorization: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
